/* hw/rtl/dra_pkg.sv */
// ----------------------------------------------------------------------------
// dra_pkg
// Shared widths, register codes and reset values for the divider resistance
// averager and its sequential divider.
// ----------------------------------------------------------------------------
package dra_pkg;

  // field widths
  localparam int RD_W    = 10;   // adc reading
  localparam int REF_W   = 20;   // reference resistor, ohms
  localparam int LIM_W   = 22;   // open limit and result values, ohms
  localparam int SUM_W   = 32;   // burst sum and divider dividend
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LIM_W;

  // configuration register codes
  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_OHMS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_LIMIT     = CFG_IDX_W'(1);

  // register reset values
  localparam logic [REF_W-1:0] REFERENCE_OHMS_RST = REF_W'(10000);
  localparam logic [LIM_W-1:0] OPEN_LIMIT_RST     = LIM_W'(3000000);

  // reading thresholds: below OPEN_THRESH is open, margin at or below is short
  localparam logic [RD_W-1:0] OPEN_THRESH  = RD_W'(3);
  localparam logic [RD_W:0]   SHORT_MARGIN = (RD_W+1)'(3);

  // parameter defaults
  localparam int NUM_READS_DEF    = 8;
  localparam int NUM_CHANNELS_DEF = 2;

endpackage

/* hw/rtl/dra_divider.sv */
// ----------------------------------------------------------------------------
// dra_divider
// Restoring unsigned divider, one quotient bit per cycle. Operands are
// latched on start; done pulses for one cycle when the quotient is valid.
// ----------------------------------------------------------------------------
module dra_divider
  import dra_pkg::*;
#(
  parameter int NUM_W = SUM_W,
  parameter int DEN_W = RD_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] dq;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] steps;

  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W:0]   diff;

  // one restoring step
  always_comb begin
    trial = {rem, dq[NUM_W-1]};
    ge    = trial >= {1'b0, den};
    diff  = trial - {1'b0, den};
  end

  // iteration control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      // done pulses with the last step
      done <= !start && busy && (steps == CNT_W'(1));
      if (start) begin
        busy  <= 1'b1;
        steps <= CNT_W'(NUM_W);
        dq    <= dividend;
        rem   <= '0;
        den   <= divisor;
      end else if (busy) begin
        dq    <= {dq[NUM_W-2:0], ge};
        rem   <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        steps <= steps - 1'b1;
        if (steps == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient = dq;

  // a new division never starts over a running one
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");

  // done follows the last step
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("divider done without a running division");

  // the step counter is zero exactly when idle
  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    !busy |-> steps == '0)
    else $error("divider counter left running");

endmodule

/* hw/rtl/divider_resistance_averager.sv */
// ----------------------------------------------------------------------------
// divider_resistance_averager
// Turns adc reading pairs of a resistive divider into resistances, averages
// them per channel over a burst and keeps a halving moving average.
//
// Input channel (in_valid/in_ready) carries channel, supply_reading and
// sensor_reading. One transaction is worked on at a time; in_ready is low
// while it runs. A normal pair runs through the 32-step shared divider;
// an open or short pair skips it. The pair that completes a burst uses the
// divider a second time for the mean and then produces one result
// transaction on the output channel (out_valid/out_ready) with out_channel,
// burst_resistance and smoothed_resistance. Pairs for a channel at or
// above NUM_CHANNELS are dropped in the accept cycle.
// The result sits in an output register: a stalled receiver does not stop the
// next pair from being taken, only a burst end that finds the register still
// full waits for it. Config writes (cfg_valid/cfg_ready) are always taken.
// Reset restores the register defaults and clears all per-channel state.
// ----------------------------------------------------------------------------
module divider_resistance_averager
  import dra_pkg::*;
#(
  parameter int NUM_READS    = NUM_READS_DEF,
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // reading pairs
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  channel,
  input  logic [RD_W-1:0]       supply_reading,
  input  logic [RD_W-1:0]       sensor_reading,
  // burst results
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_channel,
  output logic [LIM_W-1:0]      burst_resistance,
  output logic [LIM_W-1:0]      smoothed_resistance
);

  localparam int CNT_W = $clog2(NUM_READS + 1);
  localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASS,
    S_DIV_R,
    S_ACC,
    S_DIV_B,
    S_FIN
  } state_t;

  state_t state;

  // configuration registers
  logic [REF_W-1:0] ref_ohms;
  logic [LIM_W-1:0] open_lim;

  // captured pair
  logic            ch_q;
  logic [RD_W-1:0] sup_q;
  logic [RD_W-1:0] sen_q;
  logic [SUM_W-1:0] val;

  // per-channel state
  logic [SUM_W-1:0] burst_sum   [NUM_CHANNELS];
  logic [CNT_W-1:0] burst_count [NUM_CHANNELS];
  logic [LIM_W-1:0] smoothed    [NUM_CHANNELS];
  logic             seeded      [NUM_CHANNELS];

  logic [CH_W-1:0]  idx;
  logic             ch_ok;
  logic             is_open;
  logic             is_normal;
  logic [RD_W-1:0]  diff;
  logic [REF_W+RD_W-1:0] product;
  logic [SUM_W-1:0] sum_total;
  logic [CNT_W-1:0] cnt_inc;
  logic             burst_end;
  logic [LIM_W-1:0] burst_c;
  logic [LIM_W:0]   avg_sum;
  logic [LIM_W-1:0] smoothed_next;
  logic             out_free;

  logic             div_start;
  logic [SUM_W-1:0] div_dividend;
  logic [RD_W-1:0]  div_divisor;
  logic             div_busy;
  logic             div_done;
  logic [SUM_W-1:0] div_quotient;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign idx       = CH_W'(ch_q);
  assign ch_ok     = ({31'b0, channel} < 32'(NUM_CHANNELS));

  // pair classification and numerator
  always_comb begin
    is_open   = sen_q < OPEN_THRESH;
    is_normal = !is_open && ({1'b0, sup_q} > ({1'b0, sen_q} + SHORT_MARGIN));
    diff      = sup_q - sen_q;
    product   = ref_ohms * diff;
  end

  // burst accumulation
  always_comb begin
    sum_total = burst_sum[idx] + val;
    cnt_inc   = burst_count[idx] + 1'b1;
    burst_end = (cnt_inc == CNT_W'(NUM_READS));
  end

  // clamp and smoothing
  always_comb begin
    burst_c       = (val > {{(SUM_W-LIM_W){1'b0}}, open_lim}) ? open_lim : val[LIM_W-1:0];
    avg_sum       = {1'b0, burst_c} + {1'b0, smoothed[idx]};
    smoothed_next = seeded[idx] ? avg_sum[LIM_W:1] : burst_c;
    out_free      = !out_valid || out_ready;
  end

  // shared divider operands
  always_comb begin
    div_start    = 1'b0;
    div_dividend = {{(SUM_W-REF_W-RD_W){1'b0}}, product};
    div_divisor  = sen_q;
    case (state)
      S_CLASS: begin
        div_start = is_normal;
      end
      S_ACC: begin
        div_start    = burst_end;
        div_dividend = sum_total;
        div_divisor  = RD_W'(NUM_READS);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  dra_divider #(
    .NUM_W (SUM_W),
    .DEN_W (RD_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_ohms <= REFERENCE_OHMS_RST;
      open_lim <= OPEN_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REFERENCE_OHMS: ref_ohms <= cfg_data[REF_W-1:0];
        REG_OPEN_LIMIT:     open_lim <= cfg_data;
        default:            ;
      endcase
    end
  end

  // sequencer, channel state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        burst_sum[i]   <= '0;
        burst_count[i] <= '0;
        smoothed[i]    <= '0;
        seeded[i]      <= 1'b0;
      end
    end else begin
      // a loading burst end refills the register itself
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && ch_ok) begin
            ch_q  <= channel;
            sup_q <= supply_reading;
            sen_q <= sensor_reading;
            state <= S_CLASS;
          end
        end
        S_CLASS: begin
          if (is_normal) begin
            state <= S_DIV_R;
          end else begin
            val   <= is_open ? {{(SUM_W-LIM_W){1'b0}}, open_lim} : SUM_W'(1);
            state <= S_ACC;
          end
        end
        S_DIV_R: begin
          if (div_done) begin
            val   <= div_quotient;
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (burst_end) begin
            burst_sum[idx]   <= '0;
            burst_count[idx] <= '0;
            state            <= S_DIV_B;
          end else begin
            burst_sum[idx]   <= sum_total;
            burst_count[idx] <= cnt_inc;
            state            <= S_IDLE;
          end
        end
        S_DIV_B: begin
          if (div_done) begin
            val   <= div_quotient;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            smoothed[idx]       <= smoothed_next;
            seeded[idx]         <= 1'b1;
            out_valid           <= 1'b1;
            out_channel         <= ch_q;
            burst_resistance    <= burst_c;
            smoothed_resistance <= smoothed_next;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // divider is only waited on while it is running or just finished
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_R || state == S_DIV_B) |-> (div_busy || div_done))
    else $error("waiting on an idle divider");

  // a finished burst reaches the output register once it is free
  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free) |=> out_valid && state == S_IDLE)
    else $error("burst result not loaded");

  // a delivered burst mean never exceeds the open limit
  a_clamped: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> burst_resistance <= open_lim)
    else $error("burst result above open limit");

  // channel zero's count stays below a full burst
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    burst_count[0] < CNT_W'(NUM_READS))
    else $error("burst count overran");

endmodule

/* bench/dra_burst_checker.sv */
// ----------------------------------------------------------------------------
// dra_burst_checker
// Watches the configuration, pair and result channels of the divider
// resistance averager. It keeps its own copy of the registers and the
// per-channel burst state, predicts each burst result and compares every
// result transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module dra_burst_checker
  import dra_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  channel,
  input  logic [RD_W-1:0]       supply_reading,
  input  logic [RD_W-1:0]       sensor_reading,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_channel,
  input  logic [LIM_W-1:0]      burst_resistance,
  input  logic [LIM_W-1:0]      smoothed_resistance,
  output int                    fail_count,
  output int                    results_due
);

  typedef struct packed {
    logic             ch;
    logic [LIM_W-1:0] burst;
    logic [LIM_W-1:0] smooth;
  } burst_result_t;

  burst_result_t    burst_results_q[$];

  // shadow registers and per-channel burst state
  logic [REF_W-1:0] ref_ohms;
  logic [LIM_W-1:0] limit_ohms;
  logic [SUM_W-1:0] acc_sum   [NUM_CHANNELS_DEF];
  logic [3:0]       acc_count [NUM_CHANNELS_DEF];
  logic [LIM_W-1:0] avg_ohms  [NUM_CHANNELS_DEF];
  logic             seeded    [NUM_CHANNELS_DEF];

  initial begin
    fail_count  = 0;
    results_due = 0;
  end

  // one mismatching field
  task automatic report(input string field, input logic [LIM_W-1:0] want,
                        input logic [LIM_W-1:0] got);
    $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    fail_count = fail_count + 1;
  endtask

  always @(posedge clk) begin
    logic [SUM_W-1:0] ohms;
    logic [SUM_W-1:0] mean_full;
    logic [LIM_W-1:0] mean;
    logic [LIM_W:0]   total;
    burst_result_t    want;
    if (rst) begin
      ref_ohms   = REFERENCE_OHMS_RST;
      limit_ohms = OPEN_LIMIT_RST;
      for (int c = 0; c < NUM_CHANNELS_DEF; c++) begin
        acc_sum[c]   = '0;
        acc_count[c] = '0;
        avg_ohms[c]  = '0;
        seeded[c]    = 1'b0;
      end
      burst_results_q.delete();
    end else begin
      // register write transaction, unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_REFERENCE_OHMS: ref_ohms = cfg_data[REF_W-1:0];
          REG_OPEN_LIMIT:     limit_ohms = cfg_data;
          default: ;
        endcase
      end

      // result transaction against the oldest prediction
      if (out_valid && out_ready) begin
        if (burst_results_q.size() == 0) begin
          $display("%0t: unexpected result expected none actual ch %0d burst %0d smooth %0d",
                   $time, out_channel, burst_resistance, smoothed_resistance);
          fail_count = fail_count + 1;
        end else begin
          want = burst_results_q.pop_front();
          if (out_channel !== want.ch)
            report("out_channel", LIM_W'(want.ch), LIM_W'(out_channel));
          if (burst_resistance !== want.burst)
            report("burst_resistance", want.burst, burst_resistance);
          if (smoothed_resistance !== want.smooth)
            report("smoothed_resistance", want.smooth, smoothed_resistance);
        end
      end

      // pair transaction: resistance of the pair, then burst bookkeeping
      if (in_valid && in_ready) begin
        if (sensor_reading < OPEN_THRESH)
          ohms = SUM_W'(limit_ohms);
        else if ({1'b0, supply_reading} <= {1'b0, sensor_reading} + SHORT_MARGIN)
          ohms = SUM_W'(1);
        else
          ohms = SUM_W'((64'(ref_ohms) * 64'(supply_reading - sensor_reading))
                        / 64'(sensor_reading));
        acc_sum[channel]   = acc_sum[channel] + ohms;
        acc_count[channel] = acc_count[channel] + 4'd1;
        if (acc_count[channel] == NUM_READS_DEF) begin
          mean_full = acc_sum[channel] / NUM_READS_DEF;
          mean = (mean_full > SUM_W'(limit_ohms)) ? limit_ohms : mean_full[LIM_W-1:0];
          // first burst seeds the smoothed value, later ones halve the sum
          if (seeded[channel]) begin
            total = {1'b0, mean} + {1'b0, avg_ohms[channel]};
            avg_ohms[channel] = total[LIM_W:1];
          end else begin
            avg_ohms[channel] = mean;
            seeded[channel]   = 1'b1;
          end
          acc_sum[channel]   = '0;
          acc_count[channel] = '0;
          want.ch     = channel;
          want.burst  = mean;
          want.smooth = avg_ohms[channel];
          burst_results_q.push_back(want);
        end
      end
    end
    results_due = burst_results_q.size();
  end

endmodule

/* bench/divider_resistance_averager_tb.sv */
// ----------------------------------------------------------------------------
// divider_resistance_averager_tb
// Drives reading pairs and register writes into the divider resistance
// averager with random gaps on the sender and random stalls on the receiver.
// A directed part covers the reading extremes and the open, short and normal
// cases; random phases then run over several register settings, including the
// minimum, maximum and zero open limit, and one long receiver hold-off.
// ----------------------------------------------------------------------------
module divider_resistance_averager_tb;
  import dra_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
  localparam int PHASE_PAIRS = 100;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES = 1500;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  channel = 1'b0;
  logic [RD_W-1:0]       supply_reading = '0;
  logic [RD_W-1:0]       sensor_reading = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_channel;
  logic [LIM_W-1:0]      burst_resistance;
  logic [LIM_W-1:0]      smoothed_resistance;

  int   send_idle_pct = 12;
  int   recv_idle_pct = 46;
  logic hold_req = 1'b0;
  logic out_hold = 1'b0;
  int   fail_count;
  int   results_due;

  always #5 clk = ~clk;

  divider_resistance_averager uut (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .channel            (channel),
    .supply_reading     (supply_reading),
    .sensor_reading     (sensor_reading),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_channel        (out_channel),
    .burst_resistance   (burst_resistance),
    .smoothed_resistance(smoothed_resistance)
  );

  dra_burst_checker burst_check (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .channel            (channel),
    .supply_reading     (supply_reading),
    .sensor_reading     (sensor_reading),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_channel        (out_channel),
    .burst_resistance   (burst_resistance),
    .smoothed_resistance(smoothed_resistance),
    .fail_count         (fail_count),
    .results_due        (results_due)
  );

  // receiver: random stalls, forced low during the hold-off
  always @(negedge clk) begin
    out_ready <= !out_hold && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // long receiver hold-off so the result register fills and the input stalls
  initial begin
    wait (hold_req);
    out_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    out_hold <= 1'b0;
  end

  // run limit
  initial begin
    #5000000;
    $display("divider_resistance_averager_tb failed");
    $finish;
  end

  // one pair transaction; called just after a falling edge
  task automatic offer_pair(input logic ch, input int sup, input int sen);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    channel        <= ch;
    supply_reading <= RD_W'(sup);
    sensor_reading <= RD_W'(sen);
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // random pair, weighted toward normal readings with open, short and edge mixed in
  task automatic offer_random_pair();
    int pick;
    int sup;
    int sen;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      sen = $urandom_range(3, 1019);
      sup = $urandom_range(sen + 4, 1023);
    end else if (pick < 55) begin
      sen = $urandom_range(0, 1023);
      sup = $urandom_range(0, 1023);
    end else if (pick < 70) begin
      sen = $urandom_range(3, 1023);
      sup = $urandom_range(0, (sen + 3 > 1023) ? 1023 : sen + 3);
    end else if (pick < 80) begin
      sen = $urandom_range(0, 2);
      sup = $urandom_range(0, 1023);
    end else if (pick < 90) begin
      // difference right at the short margin or one above
      sen = $urandom_range(3, 1019);
      sup = sen + $urandom_range(3, 4);
    end else begin
      // tiny sensor reading, largest resistances
      sen = $urandom_range(3, 10);
      sup = $urandom_range(sen + 4, 1023);
    end
    offer_pair(1'($urandom_range(0, 1)), sup, sen);
  endtask

  // one register write transaction
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(data);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // wait for every predicted result, then for the block to go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reading extremes and each resistance case at reset settings
    offer_pair(1'b0, 1023, 3);      // largest normal value
    offer_pair(1'b0, 7, 3);         // difference just above the short margin
    offer_pair(1'b0, 6, 3);         // difference at the margin is short
    offer_pair(1'b0, 3, 1023);      // supply below sensor is short
    offer_pair(1'b0, 1023, 2);      // open
    offer_pair(1'b0, 0, 0);         // open, all zero
    offer_pair(1'b0, 1023, 1023);   // equal full scale is short
    offer_pair(1'b0, 1023, 1019);   // normal at the top of the sensor range
    offer_pair(1'b1, 512, 256);
    offer_pair(1'b1, 1000, 3);
    offer_pair(1'b1, 0, 1023);
    offer_pair(1'b1, 4, 0);
    offer_pair(1'b1, 1023, 1);
    offer_pair(1'b1, 682, 341);
    offer_pair(1'b1, 700, 696);
    offer_pair(1'b1, 1023, 4);
    // second burst on channel 0 exercises the smoothing
    for (int i = 0; i < 8; i++) offer_pair(1'b0, 1023 - i, 3 + i);
    settle();

    // random phases over several register settings
    for (int phase = 0; phase < 6; phase++) begin
      if (phase < 2) begin
        send_idle_pct = 12;
        recv_idle_pct = 46;
      end else if (phase < 4) begin
        send_idle_pct = 46;
        recv_idle_pct = 12;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0: begin
          write_reg(REG_REFERENCE_OHMS, 1);
          write_reg(REG_OPEN_LIMIT, 1);
          write_reg(REG_SPARE_A, $urandom_range(0, 4194303));
        end
        1: begin
          // upper data bits beyond the reference width are dropped
          write_reg(REG_REFERENCE_OHMS, 4194303);
          write_reg(REG_OPEN_LIMIT, 4194303);
        end
        2: begin
          write_reg(REG_REFERENCE_OHMS, $urandom_range(1, 1048575));
          write_reg(REG_OPEN_LIMIT, 4000000);
        end
        3: begin
          // zero open limit clamps every burst to zero
          write_reg(REG_REFERENCE_OHMS, 10000);
          write_reg(REG_OPEN_LIMIT, 0);
        end
        4: begin
          write_reg(REG_REFERENCE_OHMS, 1048575);
          write_reg(REG_OPEN_LIMIT, 3000000);
          write_reg(REG_SPARE_B, $urandom_range(0, 4194303));
          hold_req <= 1'b1;
        end
        default: begin
          write_reg(REG_REFERENCE_OHMS, $urandom_range(1, 1048575));
          write_reg(REG_OPEN_LIMIT, $urandom_range(1, 4000000));
        end
      endcase
      for (int i = 0; i < PHASE_PAIRS; i++) offer_random_pair();
      settle();
    end

    if (fail_count == 0 && results_due == 0) begin
      $display("divider_resistance_averager_tb passed");
    end else begin
      $display("divider_resistance_averager_tb failed");
    end
    $finish;
  end

endmodule

/* divider_resistance_averager.f */
hw/rtl/dra_pkg.sv
hw/rtl/dra_divider.sv
hw/rtl/divider_resistance_averager.sv
bench/dra_burst_checker.sv
bench/divider_resistance_averager_tb.sv
